/* hdl/bsd_pkg.sv */
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared codes and the per-word control struct for the Bezier split and
// derivative unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bsd_pkg;

  localparam logic CMD_SPLIT = 1'b0;
  localparam logic CMD_DERIV = 1'b1;

  localparam logic [1:0] DEG_NONE  = 2'd0;
  localparam logic [1:0] DEG_LINE  = 2'd1;
  localparam logic [1:0] DEG_QUAD  = 2'd2;
  localparam logic [1:0] DEG_CUBIC = 2'd3;

  // Decoded command that travels with each queued word.
  typedef struct packed {
    logic       cmd;
    logic [1:0] deg;       // never zero once classified
    logic [2:0] last_idx;  // point_index of the final result point
  } ctl_t;

  localparam int CTL_W = $bits(ctl_t);

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

endpackage

`default_nettype wire

/* hdl/bsd_front.sv */
// ----------------------------------------------------------------------------
// bsd_front
// Input side: decodes command and degree, saturates t to one and pushes the
// word into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_front import bsd_pkg::*; #(
  parameter int T_FRAC_BITS = 16
) (
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   cmd_i,
  input  wire logic [1:0]             degree_i,
  input  wire logic [T_FRAC_BITS:0]   t_i,
  input  wire logic                   q_ready_i,
  output logic                        q_push_o,
  output ctl_t                        ctl_o,
  output logic [T_FRAC_BITS:0]        t_sat_o
);

  localparam int TW = T_FRAC_BITS + 1;
  localparam logic [TW-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  logic [1:0] deg;

  // degree zero runs as a line
  assign deg = (degree_i == DEG_NONE) ? DEG_LINE : degree_i;

  assign t_sat_o = (t_i > T_ONE) ? T_ONE : t_i;

  always_comb begin
    ctl_o.cmd = cmd_i;
    ctl_o.deg = deg;
    if (cmd_i == CMD_DERIV) begin
      ctl_o.last_idx = {1'b0, deg - 2'd1};
    end else begin
      ctl_o.last_idx = {deg, 1'b0};
    end
  end

  assign in_ready_o = q_ready_i;
  assign q_push_o   = in_valid_i & q_ready_i;

endmodule

`default_nettype wire

/* hdl/bsd_queue.sv */
// ----------------------------------------------------------------------------
// bsd_queue
// Two-entry word queue between the input side and the point engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_queue import bsd_pkg::*; #(
  parameter int W = 224
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] wdata_i,
  output logic              ready_o,
  input  wire logic         pop_i,
  output logic              valid_o,
  output logic [W-1:0]      rdata_o
);

  logic [W-1:0]             mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0]   cnt_q, cnt_d;

  assign ready_o = (cnt_q != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/bsd_back.sv */
// ----------------------------------------------------------------------------
// bsd_back
// Point engine: runs de Casteljau in place one level per left-half point after the first, or
// scales control point differences, and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_back import bsd_pkg::*; #(
  parameter int COORD_BITS  = 24,
  parameter int T_FRAC_BITS = 16
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire logic                                         q_valid_i,
  input  wire logic [CTL_W+T_FRAC_BITS+1+8*COORD_BITS-1:0]  q_rdata_i,
  output logic                                              q_pop_o,
  output logic                                              out_valid_o,
  input  wire logic                                         out_ready_i,
  output logic signed [COORD_BITS+2:0]                      px_o,
  output logic signed [COORD_BITS+2:0]                      py_o,
  output logic [2:0]                                        point_index_o,
  output logic                                              last_o
);

  localparam int CW = COORD_BITS;
  localparam int TW = T_FRAC_BITS + 1;
  localparam int OW = COORD_BITS + 3;
  localparam int PW = CW + TW + 2;
  localparam int T_OFS   = 8 * CW;
  localparam int CTL_OFS = 8 * CW + TW;

  // engine state
  logic                busy_q, busy_d;
  logic [2:0]          k_q, k_d;
  ctl_t                ctl_q;
  logic [TW-1:0]       t_q;
  logic signed [CW-1:0] wx_q [4];
  logic signed [CW-1:0] wy_q [4];

  // output register
  logic                ov_q, ov_d;
  logic signed [OW-1:0] ox_q, oy_q;
  logic [2:0]          oidx_q;
  logic                olast_q;

  logic                adv, is_last, load, split_lvl;
  logic signed [CW:0]   dx [3];
  logic signed [CW:0]   dy [3];
  logic signed [PW-1:0] prodx [3];
  logic signed [PW-1:0] prody [3];
  logic signed [PW-1:0] shx [3];
  logic signed [PW-1:0] shy [3];
  logic signed [CW-1:0] nwx [3];
  logic signed [CW-1:0] nwy [3];
  logic [2:0]          upd;
  logic [2:0]          ridx;
  logic signed [CW:0]   dsx, dsy;
  logic signed [OW-1:0] dex, dey;
  logic signed [OW-1:0] ptx, pty;

  assign adv     = busy_q && (!ov_q || out_ready_i);
  assign is_last = (k_q == ctl_q.last_idx);
  assign load    = q_valid_i && (!busy_q || (adv && is_last));
  assign q_pop_o = load;

  // levels of the split run while emitting points 1..deg of the left half
  assign split_lvl = (ctl_q.cmd == CMD_SPLIT) && (k_q != 3'd0) &&
                     (k_q <= {1'b0, ctl_q.deg});

  // lerp lanes; differences are shared with the hodograph path
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dx[i]    = {wx_q[i+1][CW-1], wx_q[i+1]} - {wx_q[i][CW-1], wx_q[i]};
      dy[i]    = {wy_q[i+1][CW-1], wy_q[i+1]} - {wy_q[i][CW-1], wy_q[i]};
      prodx[i] = dx[i] * $signed({1'b0, t_q});
      prody[i] = dy[i] * $signed({1'b0, t_q});
      shx[i]   = prodx[i] >>> T_FRAC_BITS;
      shy[i]   = prody[i] >>> T_FRAC_BITS;
      // true sum lies between the end points, so the low bits are exact
      nwx[i]   = wx_q[i] + shx[i][CW-1:0];
      nwy[i]   = wy_q[i] + shy[i][CW-1:0];
      upd[i]   = split_lvl && ((k_q + 3'(i)) <= {1'b0, ctl_q.deg});
    end
  end

  // hodograph term
  always_comb begin
    case (k_q[1:0])
      2'd1: begin
        dsx = dx[1];
        dsy = dy[1];
      end
      2'd2: begin
        dsx = dx[2];
        dsy = dy[2];
      end
      default: begin
        dsx = dx[0];
        dsy = dy[0];
      end
    endcase
    dex = {{2{dsx[CW]}}, dsx};
    dey = {{2{dsy[CW]}}, dsy};
    case (ctl_q.deg)
      DEG_CUBIC: begin
        dex = (dex <<< 1) + dex;
        dey = (dey <<< 1) + dey;
      end
      DEG_QUAD: begin
        dex = dex <<< 1;
        dey = dey <<< 1;
      end
      default: begin
      end
    endcase
  end

  // point select; the right half sits in w after the last level
  assign ridx = k_q - {1'b0, ctl_q.deg};

  always_comb begin
    if (ctl_q.cmd == CMD_DERIV) begin
      ptx = dex;
      pty = dey;
    end else if (k_q == 3'd0) begin
      ptx = {{3{wx_q[0][CW-1]}}, wx_q[0]};
      pty = {{3{wy_q[0][CW-1]}}, wy_q[0]};
    end else if (split_lvl) begin
      ptx = {{3{nwx[0][CW-1]}}, nwx[0]};
      pty = {{3{nwy[0][CW-1]}}, nwy[0]};
    end else begin
      ptx = {{3{wx_q[ridx[1:0]][CW-1]}}, wx_q[ridx[1:0]]};
      pty = {{3{wy_q[ridx[1:0]][CW-1]}}, wy_q[ridx[1:0]]};
    end
  end

  always_comb begin
    busy_d = busy_q;
    k_d    = k_q;
    if (load) begin
      busy_d = 1'b1;
      k_d    = 3'd0;
    end else if (adv) begin
      if (is_last) begin
        busy_d = 1'b0;
      end else begin
        k_d = k_q + 3'd1;
      end
    end
    if (adv) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      k_q    <= k_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ctl_q <= ctl_t'(q_rdata_i[CTL_OFS +: CTL_W]);
      t_q   <= q_rdata_i[T_OFS +: TW];
      for (int i = 0; i < 4; i++) begin
        wx_q[i] <= q_rdata_i[(2*i)*CW +: CW];
        wy_q[i] <= q_rdata_i[(2*i+1)*CW +: CW];
      end
    end else if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (upd[i]) begin
          wx_q[i] <= nwx[i];
          wy_q[i] <= nwy[i];
        end
      end
    end
    if (adv) begin
      ox_q    <= ptx;
      oy_q    <= pty;
      oidx_q  <= k_q;
      olast_q <= is_last;
    end
  end

  assign out_valid_o   = ov_q;
  assign px_o          = ox_q;
  assign py_o          = oy_q;
  assign point_index_o = oidx_q;
  assign last_o        = olast_q;

endmodule

`default_nettype wire

/* hdl/bezier_split_and_derivative.sv */
// ----------------------------------------------------------------------------
// bezier_split_and_derivative
// De Casteljau split at t and derivative hodograph of line, quadratic and
// cubic Bezier curves in fixed point.
//
//   channel  signals                                   direction
//   in       in_valid_i / in_ready_o, cmd..t           curve word in
//   out      out_valid_o / out_ready_i, px..last       one point per word out
//
// A word yields 2*degree+1 points (split) or degree points (derivative),
// one point per cycle while the output is not stalled; the engine loads the
// next word at the edge of the previous word's last point.
// One de Casteljau level is computed per left-half point after the first by six lerp lanes.
// A two-entry queue lets input words land while the engine or output stalls.
// Reset clears queue, engine and output valid; no other setup is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module bezier_split_and_derivative import bsd_pkg::*; #(
  parameter int COORD_BITS  = 24,
  parameter int T_FRAC_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          cmd_i,
  input  wire logic [1:0]                    degree_i,
  input  wire logic signed [COORD_BITS-1:0]  p0x_i,
  input  wire logic signed [COORD_BITS-1:0]  p0y_i,
  input  wire logic signed [COORD_BITS-1:0]  p1x_i,
  input  wire logic signed [COORD_BITS-1:0]  p1y_i,
  input  wire logic signed [COORD_BITS-1:0]  p2x_i,
  input  wire logic signed [COORD_BITS-1:0]  p2y_i,
  input  wire logic signed [COORD_BITS-1:0]  p3x_i,
  input  wire logic signed [COORD_BITS-1:0]  p3y_i,
  input  wire logic [T_FRAC_BITS:0]          t_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [COORD_BITS+2:0]       px_o,
  output logic signed [COORD_BITS+2:0]       py_o,
  output logic [2:0]                         point_index_o,
  output logic                               last_o
);

  localparam int EW = CTL_W + T_FRAC_BITS + 1 + 8 * COORD_BITS;

  logic                   q_ready, q_push, q_valid, q_pop;
  ctl_t                   ctl;
  logic [T_FRAC_BITS:0]   t_sat;
  logic [EW-1:0]          q_wdata, q_rdata;

  bsd_front #(
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .degree_i   (degree_i),
    .t_i        (t_i),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .ctl_o      (ctl),
    .t_sat_o    (t_sat)
  );

  assign q_wdata = {ctl, t_sat, p3y_i, p3x_i, p2y_i, p2x_i, p1y_i, p1x_i, p0y_i, p0x_i};

  bsd_queue #(
    .W (EW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  bsd_back #(
    .COORD_BITS  (COORD_BITS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_rdata_i     (q_rdata),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .px_o          (px_o),
    .py_o          (py_o),
    .point_index_o (point_index_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bezier_split_and_derivative. Curve words go in over
// a valid/ready channel, and an in-bench de Casteljau / hodograph predictor
// queues the expected points. Every point that leaves the block is checked
// against the oldest expected point. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import bsd_pkg::*;

  localparam int COORD_BITS  = 24;
  localparam int T_FRAC_BITS = 16;
  localparam longint T_ONE   = longint'(1) << T_FRAC_BITS;

  localparam logic signed [COORD_BITS-1:0] C_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_BITS-1:0] C_MIN = 24'sh800000;

  localparam int RAND_ITEMS   = 480;
  localparam int CALM_ITEMS   = 60;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic                           cmd;
    logic [1:0]                     degree;
    logic signed [COORD_BITS-1:0]   p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;
    logic [T_FRAC_BITS:0]           t;
  } curve_t;

  typedef struct packed {
    logic [COORD_BITS+2:0] x;
    logic [COORD_BITS+2:0] y;
    logic [2:0]            idx;
    logic                  last;
  } point_t;

  class curve_scoreboard;
    point_t      expected_points[$];
    int unsigned errors;
    int unsigned points_checked;
    int unsigned splits_seen;
    int unsigned hodographs_seen;

    function int pending();
      return expected_points.size();
    endfunction

    function longint lerp_q(longint a, longint b, longint t);
      return a + (((b - a) * t) >>> T_FRAC_BITS);
    endfunction

    function void push_point(int idx, longint x, longint y, bit last);
      point_t p;
      p.x    = (COORD_BITS+3)'(x);
      p.y    = (COORD_BITS+3)'(y);
      p.idx  = 3'(idx);
      p.last = last;
      expected_points.push_back(p);
    endfunction

    // Expected points for one accepted curve word.
    function void note_curve(curve_t c);
      longint cx[4], cy[4], lx[4], ly[4], rx[4], ry[4];
      longint tq;
      int     deg;
      deg   = (c.degree == DEG_NONE) ? int'(DEG_LINE) : int'(c.degree);
      tq    = (longint'(c.t) > T_ONE) ? T_ONE : longint'(c.t);
      cx[0] = longint'($signed(c.p0x));
      cy[0] = longint'($signed(c.p0y));
      cx[1] = longint'($signed(c.p1x));
      cy[1] = longint'($signed(c.p1y));
      cx[2] = longint'($signed(c.p2x));
      cy[2] = longint'($signed(c.p2y));
      cx[3] = longint'($signed(c.p3x));
      cy[3] = longint'($signed(c.p3y));
      if (c.cmd == CMD_DERIV) begin
        hodographs_seen++;
        for (int i = 0; i < deg; i++)
          push_point(i, deg * (cx[i+1] - cx[i]), deg * (cy[i+1] - cy[i]), i == deg - 1);
        return;
      end
      splits_seen++;
      lx[0]   = cx[0];
      ly[0]   = cy[0];
      rx[deg] = cx[deg];
      ry[deg] = cy[deg];
      // cx/cy are overwritten level by level; left and right edges are kept
      for (int j = 1; j <= deg; j++) begin
        for (int i = 0; i + j <= deg; i++) begin
          cx[i] = lerp_q(cx[i], cx[i+1], tq);
          cy[i] = lerp_q(cy[i], cy[i+1], tq);
        end
        lx[j]       = cx[0];
        ly[j]       = cy[0];
        rx[deg - j] = cx[deg - j];
        ry[deg - j] = cy[deg - j];
      end
      for (int i = 0; i <= deg; i++)
        push_point(i, lx[i], ly[i], 1'b0);
      for (int i = 1; i <= deg; i++)
        push_point(deg + i, rx[i], ry[i], i == deg);
    endfunction

    function void check_point(logic [COORD_BITS+2:0] x, logic [COORD_BITS+2:0] y,
                              logic [2:0] idx, logic last);
      point_t e;
      points_checked++;
      if (expected_points.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected point: x=%0d y=%0d idx=%0d last=%0b",
                   $signed(x), $signed(y), idx, last);
        return;
      end
      e = expected_points.pop_front();
      if (x !== e.x || y !== e.y || idx !== e.idx || last !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("point mismatch: expected x=%0d y=%0d idx=%0d last=%0b, got x=%0d y=%0d idx=%0d last=%0b",
                   $signed(e.x), $signed(e.y), e.idx, e.last,
                   $signed(x), $signed(y), idx, last);
      end
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic                          cmd_i;
  logic [1:0]                    degree_i;
  logic signed [COORD_BITS-1:0]  p0x_i, p0y_i, p1x_i, p1y_i, p2x_i, p2y_i, p3x_i, p3y_i;
  logic [T_FRAC_BITS:0]          t_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic signed [COORD_BITS+2:0]  px_o, py_o;
  logic [2:0]                    point_index_o;
  logic                          last_o;

  curve_scoreboard sb = new();
  int              gap_pct;
  int              stall_pct;

  bezier_split_and_derivative #(
    .COORD_BITS  (COORD_BITS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .degree_i      (degree_i),
    .p0x_i         (p0x_i),
    .p0y_i         (p0y_i),
    .p1x_i         (p1x_i),
    .p1y_i         (p1y_i),
    .p2x_i         (p2x_i),
    .p2y_i         (p2y_i),
    .p3x_i         (p3x_i),
    .p3y_i         (p3y_i),
    .t_i           (t_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .px_o          (px_o),
    .py_o          (py_o),
    .point_index_o (point_index_o),
    .last_o        (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic curve_t make_curve(logic cmd, logic [1:0] deg, logic [T_FRAC_BITS:0] t,
                                        logic signed [COORD_BITS-1:0] x0, y0, x1, y1,
                                        logic signed [COORD_BITS-1:0] x2, y2, x3, y3);
    curve_t c;
    c.cmd    = cmd;
    c.degree = deg;
    c.t      = t;
    c.p0x = x0; c.p0y = y0; c.p1x = x1; c.p1y = y1;
    c.p2x = x2; c.p2y = y2; c.p3x = x3; c.p3y = y3;
    return c;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return C_MAX;
      1:       return C_MIN;
      2, 3:    return COORD_BITS'(int'($urandom_range(0, 2047)) - 1024);
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [T_FRAC_BITS:0] rand_t();
    case ($urandom_range(0, 9))
      0:       return (T_FRAC_BITS+1)'($urandom_range(65537, 131071));
      1:       return $urandom_range(0, 1) ? (T_FRAC_BITS+1)'(T_ONE) : '0;
      default: return (T_FRAC_BITS+1)'($urandom_range(0, 65536));
    endcase
  endfunction

  // Drive one curve word from a falling edge and hold it until accepted.
  // Returns at the falling edge after acceptance with valid still high.
  task automatic send_curve(curve_t c);
    cmd_i      = c.cmd;
    degree_i   = c.degree;
    p0x_i = c.p0x; p0y_i = c.p0y; p1x_i = c.p1x; p1y_i = c.p1y;
    p2x_i = c.p2x; p2y_i = c.p2y; p3x_i = c.p3x; p3y_i = c.p3y;
    t_i        = c.t;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_curve(c);
    @(negedge clk_i);
  endtask

  task automatic maybe_gap();
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
  endtask

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_point(px_o, py_o, point_index_o, last_o);

  initial begin : sink
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 99) < stall_pct) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
    end
  end

  // Ends the run if nothing moves on either channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    curve_t directed_q[$];
    curve_t c;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    cmd_i      = CMD_SPLIT;
    degree_i   = DEG_LINE;
    p0x_i = '0; p0y_i = '0; p1x_i = '0; p1y_i = '0;
    p2x_i = '0; p2y_i = '0; p3x_i = '0; p3y_i = '0;
    t_i        = '0;
    gap_pct    = 0;
    stall_pct  = 15;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // t at both ends, past one, and the smallest steps
    directed_q.push_back(make_curve(CMD_SPLIT, DEG_LINE, 0,
                         C_MAX, C_MIN, C_MIN, C_MAX, 0, 0, 0, 0));
    directed_q.push_back(make_curve(CMD_SPLIT, DEG_LINE, 65536,
                         C_MIN, C_MAX, C_MAX, C_MIN, 0, 0, 0, 0));
    directed_q.push_back(make_curve(CMD_SPLIT, DEG_QUAD, 32768,
                         C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, 0, 0));
    directed_q.push_back(make_curve(CMD_SPLIT, DEG_QUAD, 65536,
                         100, -200, 5000, 7000, -3000, 1234, 0, 0));
    directed_q.push_back(make_curve(CMD_SPLIT, DEG_QUAD, 0,
                         100, -200, 5000, 7000, -3000, 1234, 0, 0));
    directed_q.push_back(make_curve(CMD_SPLIT, DEG_CUBIC, 32768,
                         C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
    directed_q.push_back(make_curve(CMD_SPLIT, DEG_CUBIC, 1,
                         C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX));
    directed_q.push_back(make_curve(CMD_SPLIT, DEG_CUBIC, 65535,
                         C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN));
    directed_q.push_back(make_curve(CMD_SPLIT, DEG_CUBIC, 17'h1FFFF,
                         -5, 7, 300, -900, C_MAX, C_MIN, 12, 34));
    directed_q.push_back(make_curve(CMD_SPLIT, DEG_CUBIC, 65537,
                         C_MIN, 0, C_MAX, 0, C_MIN, 0, C_MAX, 0));
    directed_q.push_back(make_curve(CMD_SPLIT, DEG_CUBIC, 65536,
                         1, 2, 3, 4, 5, 6, 7, 8));
    // degree zero behaves as a line
    directed_q.push_back(make_curve(CMD_SPLIT, DEG_NONE, 20000,
                         -1000, 2000, 3000, -4000, C_MAX, C_MIN, C_MAX, C_MIN));
    directed_q.push_back(make_curve(CMD_DERIV, DEG_NONE, 0,
                         C_MIN, C_MAX, C_MAX, C_MIN, 1, 1, 1, 1));
    // hodograph at full range
    directed_q.push_back(make_curve(CMD_DERIV, DEG_LINE, 17'h1FFFF,
                         C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX));
    directed_q.push_back(make_curve(CMD_DERIV, DEG_QUAD, 12345,
                         C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, 0, 0));
    directed_q.push_back(make_curve(CMD_DERIV, DEG_CUBIC, 65536,
                         C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX));
    directed_q.push_back(make_curve(CMD_DERIV, DEG_CUBIC, 0,
                         C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN));
    // unused control points carry junk
    directed_q.push_back(make_curve(CMD_SPLIT, DEG_LINE, 40000,
                         10, 20, 30, 40, C_MAX, C_MIN, C_MIN, C_MAX));
    directed_q.push_back(make_curve(CMD_SPLIT, DEG_QUAD, 40000,
                         10, 20, 30, 40, 50, 60, C_MIN, C_MAX));
    directed_q.push_back(make_curve(CMD_DERIV, DEG_QUAD, 40000,
                         10, 20, 30, 40, 50, 60, C_MAX, C_MIN));
    directed_q.push_back(make_curve(CMD_SPLIT, DEG_CUBIC, 21846,
                         0, 0, 0, 0, 0, 0, 0, 0));

    foreach (directed_q[i])
      send_curve(directed_q[i]);

    // let the block drain completely before the random part
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n >= RAND_ITEMS - CALM_ITEMS) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else if (n % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 15;
          default: gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end
      c = make_curve(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), rand_t(),
                     rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord(), rand_coord());
      maybe_gap();
      send_curve(c);
    end
    in_valid_i = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d split words and %0d hodograph words, %0d points checked",
             sb.splits_seen, sb.hodographs_seen, sb.points_checked);
    $display("mismatches: %0d, points still outstanding: %0d", sb.errors, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
hdl/bsd_pkg.sv
hdl/bsd_front.sv
hdl/bsd_queue.sv
hdl/bsd_back.sv
hdl/bezier_split_and_derivative.sv
tb/tb.sv
